// ----- hdl/hjrt_pkg.sv -----
// ----------------------------------------------------------------------------
// hjrt_pkg
// Shared constants for the hex jump route table.
// ----------------------------------------------------------------------------
package hjrt_pkg;

  localparam int COORD_W = 5;
  localparam int LEN_W   = 8;
  localparam int CELL_W  = 2 * COORD_W;

  localparam logic       CMD_LOAD   = 1'b0;
  localparam logic       CMD_QUERY  = 1'b1;

  localparam logic [LEN_W-1:0] NEAR_LIMIT = 8'd2;
  localparam logic [LEN_W-1:0] SAT_MAX    = 8'd255;

endpackage

// ----- hdl/hjrt_ram.sv -----
// ----------------------------------------------------------------------------
// hjrt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hjrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/hex_jump_route_table_top.sv -----
// ----------------------------------------------------------------------------
// hex_jump_route_table_top
// Loads hex cells, builds a route length table, answers route queries.
// ----------------------------------------------------------------------------
// A load within capacity and grid is written to the cell RAM. The load marked
// last starts the build once two or more cells are held: a near pass over
// every cell pair, then sweeps of the matrix RAM until one makes no change,
// each sweep starting with a setup state; an open pair reads the single matrix
// read port twice per cell and accumulates; a closed pair is only checked.
// A query scans the cell RAM, reading and comparing each loaded cell, then
// reads the matrix and hands the result to the output register, waiting
// while the output is held. No request is taken during a build or a query.
// The matrix RAM needs no clearing: entries are only read after the build
// has written them, and before a build a query returns 0.
module hex_jump_route_table_top #(
  parameter int MAX_CELLS = 64,
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [hjrt_pkg::COORD_W-1:0] in_col,
  input  logic [hjrt_pkg::COORD_W-1:0] in_row,
  input  logic [hjrt_pkg::COORD_W-1:0] in_other_col,
  input  logic [hjrt_pkg::COORD_W-1:0] in_other_row,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hjrt_pkg::LEN_W-1:0]  out_route_length
);

  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int IW = $clog2(MAX_CELLS);
  localparam int MD = MAX_CELLS * MAX_CELLS;
  localparam int AW = $clog2(MD);
  localparam int LW = hjrt_pkg::LEN_W;
  localparam int PW = hjrt_pkg::COORD_W;
  localparam int XW = hjrt_pkg::CELL_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PUSH   = 5'd1;
  localparam logic [4:0] S_Q_RD   = 5'd2;
  localparam logic [4:0] S_Q_CMP  = 5'd3;
  localparam logic [4:0] S_Q_MAT  = 5'd4;
  localparam logic [4:0] S_Q_OUT  = 5'd5;
  localparam logic [4:0] S_NA_RD  = 5'd6;
  localparam logic [4:0] S_NA_LAT = 5'd7;
  localparam logic [4:0] S_NB_RD  = 5'd8;
  localparam logic [4:0] S_NB_WR  = 5'd9;
  localparam logic [4:0] S_SW_INI = 5'd10;
  localparam logic [4:0] S_P_RD   = 5'd11;
  localparam logic [4:0] S_P_CHK  = 5'd12;
  localparam logic [4:0] S_K_P    = 5'd13;
  localparam logic [4:0] S_K_Q    = 5'd14;
  localparam logic [4:0] S_K_ACC  = 5'd15;
  localparam logic [4:0] S_WR     = 5'd16;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(32'(r) * 32'(MAX_CELLS) + 32'(c));
  endfunction

  function automatic logic [AW-1:0] oaddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return (r < c) ? maddr(r, c) : maddr(c, r);
  endfunction

  // control
  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ready_r, ready_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          changed_r, changed_nxt;
  logic          found_r, found_nxt;
  logic          fa_r, fa_nxt, fb_r, fb_nxt;
  // payload
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic [IW-1:0] ida_r, ida_nxt, idb_r, idb_nxt;
  logic [XW-1:0] qa_r, qa_nxt, qb_r, qb_nxt, ca_r, ca_nxt;
  logic [LW-1:0] p_r, p_nxt, best_r, best_nxt, res_r, res_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;

  // memories
  logic          cell_we, cell_re;
  logic [IW-1:0] cell_waddr, cell_raddr;
  logic [XW-1:0] cell_wdata, cell_rdata;
  logic          mat_we, mat_re;
  logic [AW-1:0] mat_waddr, mat_raddr;
  logic [LW-1:0] mat_wdata, mat_rdata;

  hjrt_ram #(.WIDTH(XW), .DEPTH(MAX_CELLS)) u_cells (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .re(cell_re), .raddr(cell_raddr), .rdata(cell_rdata)
  );

  hjrt_ram #(.WIDTH(LW), .DEPTH(MD)) u_matrix (
    .clk, .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .re(mat_re), .raddr(mat_raddr), .rdata(mat_rdata)
  );

  // hex distance between latched cell a and the cell on the read port
  logic signed [8:0] x1, x2, z1, z2, dx, dz, dy, adx, ady, adz, dmax;
  logic [LW-1:0]     near_len;

  always_comb begin
    x1 = 9'(ca_r[XW-1:PW]);
    x2 = 9'(cell_rdata[XW-1:PW]);
    z1 = 9'(ca_r[PW-1:0]) - 9'(ca_r[XW-1:PW+1]);
    z2 = 9'(cell_rdata[PW-1:0]) - 9'(cell_rdata[XW-1:PW+1]);
    dx = x1 - x2;
    dz = z1 - z2;
    dy = -dx - dz;
    adx = dx[8] ? -dx : dx;
    ady = dy[8] ? -dy : dy;
    adz = dz[8] ? -dz : dz;
    dmax = (adx > ady) ? adx : ady;
    dmax = (dmax > adz) ? dmax : adz;
    near_len = (dmax <= 9'(hjrt_pkg::NEAR_LIMIT)) ? LW'(dmax) : '0;
  end

  logic [CW-1:0] n_m1, n_m2, load_base;
  logic          load_ok, pair_last_b, pair_last_a;
  logic [LW-1:0] pq, q_val;
  logic [LW:0]   sum;

  assign n_m1        = count_r - CW'(1);
  assign n_m2        = count_r - CW'(2);
  assign pair_last_b = (b_r == n_m1);
  assign pair_last_a = (a_r == n_m2);
  assign load_base   = ready_r ? '0 : count_r;
  assign load_ok     = (load_base < CW'(MAX_CELLS))
                    && (32'(in_col) < 32'(GRID_COLS))
                    && (32'(in_row) < 32'(GRID_ROWS));

  assign q_val = (k_r == b_r) ? '0 : mat_rdata;
  assign sum   = {1'b0, p_r} + {1'b0, q_val};
  assign pq    = sum[LW] ? hjrt_pkg::SAT_MAX : sum[LW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ready_nxt     = ready_r;
    out_valid_nxt = out_valid_r;
    changed_nxt   = changed_r;
    found_nxt     = found_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    ida_nxt       = ida_r;
    idb_nxt       = idb_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    ca_nxt        = ca_r;
    p_nxt         = p_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_len_nxt   = out_len_r;
    cell_we       = 1'b0;
    cell_waddr    = load_base[IW-1:0];
    cell_wdata    = {in_col, in_row};
    cell_re       = 1'b0;
    cell_raddr    = a_r[IW-1:0];
    mat_we        = 1'b0;
    mat_waddr     = maddr(a_r[IW-1:0], b_r[IW-1:0]);
    mat_wdata     = near_len;
    mat_re        = 1'b0;
    mat_raddr     = maddr(a_r[IW-1:0], b_r[IW-1:0]);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == hjrt_pkg::CMD_LOAD) begin
            ready_nxt = 1'b0;
            count_nxt = load_base;
            if (load_ok) begin
              cell_we   = 1'b1;
              count_nxt = load_base + CW'(1);
            end
            if (in_last) begin
              if (count_nxt < CW'(2)) begin
                ready_nxt = 1'b1;
              end else begin
                a_nxt     = '0;
                state_nxt = S_NA_RD;
              end
            end
          end else begin
            qa_nxt = {in_col, in_row};
            qb_nxt = {in_other_col, in_other_row};
            fa_nxt = 1'b0;
            fb_nxt = 1'b0;
            k_nxt  = '0;
            state_nxt = (count_r == '0) ? S_Q_MAT : S_Q_RD;
          end
        end
      end
      S_Q_RD: begin
        cell_re    = 1'b1;
        cell_raddr = k_r[IW-1:0];
        state_nxt  = S_Q_CMP;
      end
      S_Q_CMP: begin
        // lowest matching id wins
        if (!fa_r && cell_rdata == qa_r) begin
          fa_nxt  = 1'b1;
          ida_nxt = k_r[IW-1:0];
        end
        if (!fb_r && cell_rdata == qb_r) begin
          fb_nxt  = 1'b1;
          idb_nxt = k_r[IW-1:0];
        end
        k_nxt     = k_r + CW'(1);
        state_nxt = (k_r == n_m1) ? S_Q_MAT : S_Q_RD;
      end
      S_Q_MAT: begin
        if (fa_r && fb_r && ready_r && ida_r != idb_r) begin
          mat_re    = 1'b1;
          mat_raddr = oaddr(ida_r, idb_r);
          state_nxt = S_Q_OUT;
        end else begin
          res_nxt   = '0;
          state_nxt = S_PUSH;
        end
      end
      S_Q_OUT: begin
        res_nxt   = mat_rdata;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      S_NA_RD: begin
        cell_re    = 1'b1;
        cell_raddr = a_r[IW-1:0];
        state_nxt  = S_NA_LAT;
      end
      S_NA_LAT: begin
        ca_nxt    = cell_rdata;
        b_nxt     = a_r + CW'(1);
        state_nxt = S_NB_RD;
      end
      S_NB_RD: begin
        cell_re    = 1'b1;
        cell_raddr = b_r[IW-1:0];
        state_nxt  = S_NB_WR;
      end
      S_NB_WR: begin
        mat_we = 1'b1;
        if (pair_last_b) begin
          if (pair_last_a) begin
            state_nxt = S_SW_INI;
          end else begin
            a_nxt     = a_r + CW'(1);
            state_nxt = S_NA_RD;
          end
        end else begin
          b_nxt     = b_r + CW'(1);
          state_nxt = S_NB_RD;
        end
      end
      S_SW_INI: begin
        a_nxt       = '0;
        b_nxt       = CW'(1);
        changed_nxt = 1'b0;
        state_nxt   = S_P_RD;
      end
      S_P_RD: begin
        mat_re    = 1'b1;
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        k_nxt     = '0;
        found_nxt = 1'b0;
        state_nxt = (mat_rdata == '0) ? S_K_P : S_WR;
      end
      S_K_P: begin
        mat_re    = 1'b1;
        mat_raddr = oaddr(a_r[IW-1:0], k_r[IW-1:0]);
        state_nxt = S_K_Q;
      end
      S_K_Q: begin
        // the diagonal is never stored; it reads as zero
        p_nxt     = (k_r == a_r) ? '0 : mat_rdata;
        mat_re    = 1'b1;
        mat_raddr = oaddr(b_r[IW-1:0], k_r[IW-1:0]);
        state_nxt = S_K_ACC;
      end
      S_K_ACC: begin
        if (p_r != '0 && q_val != '0 && (!found_r || pq < best_r)) begin
          best_nxt  = pq;
          found_nxt = 1'b1;
        end
        k_nxt     = k_r + CW'(1);
        state_nxt = (k_r == n_m1) ? S_WR : S_K_P;
      end
      S_WR: begin
        // found_r is clear for pairs that were already closed
        if (found_r) begin
          mat_we      = 1'b1;
          mat_wdata   = best_r;
          changed_nxt = 1'b1;
        end
        found_nxt = 1'b0;
        if (pair_last_b) begin
          if (pair_last_a) begin
            if (changed_nxt) begin
              state_nxt = S_SW_INI;
            end else begin
              ready_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            a_nxt     = a_r + CW'(1);
            b_nxt     = a_r + CW'(2);
            state_nxt = S_P_RD;
          end
        end else begin
          b_nxt     = b_r + CW'(1);
          state_nxt = S_P_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      changed_r   <= 1'b0;
      found_r     <= 1'b0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      changed_r   <= changed_nxt;
      found_r     <= found_nxt;
      fa_r        <= fa_nxt;
      fb_r        <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    ida_r     <= ida_nxt;
    idb_r     <= idb_nxt;
    qa_r      <= qa_nxt;
    qb_r      <= qb_nxt;
    ca_r      <= ca_nxt;
    p_r       <= p_nxt;
    best_r    <= best_nxt;
    res_r     <= res_nxt;
    out_len_r <= out_len_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_route_length = out_len_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CELLS))
    else $error("cell count above capacity");

  a_mat_we_build: assert property (@(posedge clk) disable iff (!rst_n)
    mat_we |-> (state_r == S_NB_WR || state_r == S_WR))
    else $error("matrix written outside build");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_RD || state_r == S_NB_RD) |-> (b_r > a_r && b_r < count_r))
    else $error("pair indices out of order");

  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> ($past(state_r) == S_WR || $past(state_r) == S_IDLE))
    else $error("table ready set outside build end");

endmodule
